// ===== hw/rtl/c80dtu_pkg.sv =====
// Types, command codes and cycle charges for the 8080 data transfer unit.
`timescale 1ns / 1ps
`default_nettype none

package c80dtu_pkg;

	// Command codes carried by an input beat.
	localparam logic [3:0] CMD_MOV    = 4'd0;
	localparam logic [3:0] CMD_LD_HL  = 4'd1;
	localparam logic [3:0] CMD_ST_HL  = 4'd2;
	localparam logic [3:0] CMD_MVI    = 4'd3;
	localparam logic [3:0] CMD_MVI_M  = 4'd4;
	localparam logic [3:0] CMD_LXI    = 4'd5;
	localparam logic [3:0] CMD_LDA    = 4'd7;
	localparam logic [3:0] CMD_STA    = 4'd8;
	localparam logic [3:0] CMD_LHLD   = 4'd9;
	localparam logic [3:0] CMD_SHLD   = 4'd10;
	localparam logic [3:0] CMD_LDAX   = 4'd11;
	localparam logic [3:0] CMD_STAX   = 4'd12;
	localparam logic [3:0] CMD_XCHG   = 4'd13;

	// Register file indexes.
	localparam logic [2:0] REG_B = 3'd0;
	localparam logic [2:0] REG_C = 3'd1;
	localparam logic [2:0] REG_D = 3'd2;
	localparam logic [2:0] REG_E = 3'd3;
	localparam logic [2:0] REG_H = 3'd4;
	localparam logic [2:0] REG_L = 3'd5;
	localparam logic [2:0] REG_A = 3'd7;

	// Register pair selects.
	localparam logic [1:0] PAIR_BC = 2'd0;
	localparam logic [1:0] PAIR_DE = 2'd1;
	localparam logic [1:0] PAIR_HL = 2'd2;
	localparam logic [1:0] PAIR_SP = 2'd3;

	// Machine cycles charged per instruction class.
	localparam logic [4:0] CYC_NOP  = 5'd4;
	localparam logic [4:0] CYC_MOV  = 5'd5;
	localparam logic [4:0] CYC_MEM  = 5'd7;
	localparam logic [4:0] CYC_IMM  = 5'd10;
	localparam logic [4:0] CYC_DIR  = 5'd13;
	localparam logic [4:0] CYC_WORD = 5'd16;

	typedef struct packed {
		logic [3:0] command;
		logic [2:0] dst_reg;
		logic [2:0] src_reg;
		logic [1:0] pair_sel;
		logic [7:0] imm_low;
		logic [7:0] imm_high;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  cycles_taken;
		logic [15:0] pc_value;
		logic [31:0] cycle_total;
		logic [7:0]  moved_value;
	} out_item_t;

	// Cycles charged for a command.
	function automatic logic [4:0] cmd_cycles(input logic [3:0] cmd);
		logic [4:0] cyc;
		case (cmd)
			CMD_MOV:                                    cyc = CYC_MOV;
			CMD_LD_HL, CMD_ST_HL, CMD_MVI,
			CMD_LDAX, CMD_STAX:                         cyc = CYC_MEM;
			CMD_MVI_M, CMD_LXI:                         cyc = CYC_IMM;
			CMD_LDA, CMD_STA:                           cyc = CYC_DIR;
			CMD_LHLD, CMD_SHLD:                         cyc = CYC_WORD;
			default:                                    cyc = CYC_NOP;
		endcase
		return cyc;
	endfunction

	// Program counter advance, the number of operand bytes.
	function automatic logic [1:0] cmd_pc_inc(input logic [3:0] cmd);
		logic [1:0] inc;
		case (cmd)
			CMD_MVI, CMD_MVI_M:                         inc = 2'd1;
			CMD_LXI, CMD_LDA, CMD_STA,
			CMD_LHLD, CMD_SHLD:                         inc = 2'd2;
			default:                                    inc = 2'd0;
		endcase
		return inc;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/c80dtu_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module c80dtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cpu8080_data_transfer_unit.sv =====
// Top level of the 8080 data transfer unit: register file, counters and byte memory.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------
//   cmd      | in        | cmd_valid, cmd_stall | cmd_item  (in_item_t)
//   res      | out       | res_valid, res_stall | res_item  (out_item_t)
//
// An instruction goes from S_IDLE to S_FIN, LHLD and SHLD by way of S_SECOND: the
// single memory port does one byte access per cycle, the first as the beat is accepted.
// The result lands in an output register, so a new beat is taken while it waits.
// A result is held in the final state while the output register is full and stalled.
// Reset clears the register file, stack pointer, program counter and cycle total;
// the byte memory has no reset and no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module cpu8080_data_transfer_unit #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cmd_valid,
	output logic                        cmd_stall,
	input  wire c80dtu_pkg::in_item_t   cmd_item,
	output logic                        res_valid,
	input  wire logic                   res_stall,
	output c80dtu_pkg::out_item_t       res_item
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SECOND,
		S_FIN
	} state_t;

	state_t                state_q;
	logic [7:0]            regs_q [8];
	logic [15:0]           sp_q;
	logic [15:0]           pc_q;
	logic [31:0]           total_q;
	logic                  res_valid_q;
	c80dtu_pkg::out_item_t res_item_q;

	// Latched instruction fields.
	logic [3:0]            cmd_q;
	logic [2:0]            dst_q;
	logic [2:0]            src_q;
	logic [1:0]            pair_q;
	logic [7:0]            lo_q;
	logic [7:0]            hi_q;
	logic [15:0]           addr_q;
	logic [7:0]            byte1_q;

	logic                  accept;
	logic                  fin_fire;
	logic [15:0]           hl;
	logic [15:0]           pair_val;
	logic [15:0]           first_addr;
	logic [15:0]           next_addr;
	logic                  mem_we;
	logic                  mem_re;
	logic [15:0]           mem_addr;
	logic [7:0]            mem_wdata;
	logic [7:0]            mem_rdata;
	logic [7:0]            moved;
	logic                  first_we;
	logic                  first_re;
	logic [7:0]            first_wdata;
	logic [4:0]            cyc;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign fin_fire  = (state_q == S_FIN) && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// Register pairs seen by the first memory access.
	assign hl = {regs_q[c80dtu_pkg::REG_H], regs_q[c80dtu_pkg::REG_L]};

	always_comb begin
		unique case (cmd_item.pair_sel)
			c80dtu_pkg::PAIR_BC: pair_val = {regs_q[c80dtu_pkg::REG_B], regs_q[c80dtu_pkg::REG_C]};
			c80dtu_pkg::PAIR_DE: pair_val = {regs_q[c80dtu_pkg::REG_D], regs_q[c80dtu_pkg::REG_E]};
			c80dtu_pkg::PAIR_HL: pair_val = hl;
			default:             pair_val = sp_q;
		endcase
	end

	// First memory access, issued from the incoming beat.
	always_comb begin
		first_addr  = hl;
		first_we    = 1'b0;
		first_re    = 1'b0;
		first_wdata = regs_q[c80dtu_pkg::REG_A];
		case (cmd_item.command)
			c80dtu_pkg::CMD_LD_HL: begin
				first_re = 1'b1;
			end
			c80dtu_pkg::CMD_ST_HL: begin
				first_we    = 1'b1;
				first_wdata = regs_q[cmd_item.src_reg];
			end
			c80dtu_pkg::CMD_MVI_M: begin
				first_we    = 1'b1;
				first_wdata = cmd_item.imm_low;
			end
			c80dtu_pkg::CMD_LDA, c80dtu_pkg::CMD_LHLD: begin
				first_addr = {cmd_item.imm_high, cmd_item.imm_low};
				first_re   = 1'b1;
			end
			c80dtu_pkg::CMD_STA: begin
				first_addr = {cmd_item.imm_high, cmd_item.imm_low};
				first_we   = 1'b1;
			end
			c80dtu_pkg::CMD_SHLD: begin
				first_addr  = {cmd_item.imm_high, cmd_item.imm_low};
				first_we    = 1'b1;
				first_wdata = regs_q[c80dtu_pkg::REG_L];
			end
			c80dtu_pkg::CMD_LDAX: begin
				first_addr = pair_val;
				first_re   = 1'b1;
			end
			c80dtu_pkg::CMD_STAX: begin
				first_addr = pair_val;
				first_we   = 1'b1;
			end
			default: begin
				first_addr = hl;
			end
		endcase
	end

	// Memory port: first byte at accept, second byte of LHLD and SHLD afterwards.
	assign next_addr = addr_q + 16'd1;

	always_comb begin
		if (state_q == S_SECOND) begin
			mem_addr  = next_addr;
			mem_we    = (cmd_q == c80dtu_pkg::CMD_SHLD);
			mem_re    = (cmd_q == c80dtu_pkg::CMD_LHLD);
			mem_wdata = regs_q[c80dtu_pkg::REG_H];
		end else begin
			mem_addr  = first_addr;
			mem_we    = accept && first_we;
			mem_re    = accept && first_re;
			mem_wdata = first_wdata;
		end
	end

	c80dtu_ram #(
		.WIDTH (8),
		.DEPTH (1 << MEM_ADDR_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr[MEM_ADDR_BITS-1:0]),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// First byte moved by the instruction.
	always_comb begin
		case (cmd_q)
			c80dtu_pkg::CMD_MOV, c80dtu_pkg::CMD_ST_HL:                        moved = regs_q[src_q];
			c80dtu_pkg::CMD_LD_HL, c80dtu_pkg::CMD_LDA, c80dtu_pkg::CMD_LDAX:  moved = mem_rdata;
			c80dtu_pkg::CMD_MVI, c80dtu_pkg::CMD_MVI_M:                        moved = lo_q;
			c80dtu_pkg::CMD_STA, c80dtu_pkg::CMD_STAX:                         moved = regs_q[c80dtu_pkg::REG_A];
			c80dtu_pkg::CMD_LHLD:                                              moved = byte1_q;
			c80dtu_pkg::CMD_SHLD:                                              moved = regs_q[c80dtu_pkg::REG_L];
			default:                                                           moved = 8'd0;
		endcase
	end

	assign cyc = c80dtu_pkg::cmd_cycles(cmd_q);

	// Sequencer, architectural state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			sp_q        <= 16'd0;
			pc_q        <= 16'd0;
			total_q     <= 32'd0;
			for (int i = 0; i < 8; i++) begin
				regs_q[i] <= 8'd0;
			end
		end else begin
			// The waiting result leaves unless a new one replaces it in the same cycle.
			if (res_valid_q && !res_stall && !fin_fire) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd_item.command == c80dtu_pkg::CMD_LHLD ||
						    cmd_item.command == c80dtu_pkg::CMD_SHLD) begin
							state_q <= S_SECOND;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SECOND: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_fire) begin
						state_q     <= S_IDLE;
						res_valid_q <= 1'b1;
						pc_q        <= pc_q + {14'd0, c80dtu_pkg::cmd_pc_inc(cmd_q)};
						total_q     <= total_q + {27'd0, cyc};
						case (cmd_q)
							c80dtu_pkg::CMD_MOV, c80dtu_pkg::CMD_LD_HL, c80dtu_pkg::CMD_MVI: begin
								regs_q[dst_q] <= moved;
							end
							c80dtu_pkg::CMD_LDA, c80dtu_pkg::CMD_LDAX: begin
								regs_q[c80dtu_pkg::REG_A] <= moved;
							end
							c80dtu_pkg::CMD_LHLD: begin
								regs_q[c80dtu_pkg::REG_L] <= byte1_q;
								regs_q[c80dtu_pkg::REG_H] <= mem_rdata;
							end
							c80dtu_pkg::CMD_LXI: begin
								case (pair_q)
									c80dtu_pkg::PAIR_BC: begin
										regs_q[c80dtu_pkg::REG_B] <= hi_q;
										regs_q[c80dtu_pkg::REG_C] <= lo_q;
									end
									c80dtu_pkg::PAIR_DE: begin
										regs_q[c80dtu_pkg::REG_D] <= hi_q;
										regs_q[c80dtu_pkg::REG_E] <= lo_q;
									end
									c80dtu_pkg::PAIR_HL: begin
										regs_q[c80dtu_pkg::REG_H] <= hi_q;
										regs_q[c80dtu_pkg::REG_L] <= lo_q;
									end
									default: begin
										sp_q <= {hi_q, lo_q};
									end
								endcase
							end
							c80dtu_pkg::CMD_XCHG: begin
								regs_q[c80dtu_pkg::REG_H] <= regs_q[c80dtu_pkg::REG_D];
								regs_q[c80dtu_pkg::REG_D] <= regs_q[c80dtu_pkg::REG_H];
								regs_q[c80dtu_pkg::REG_L] <= regs_q[c80dtu_pkg::REG_E];
								regs_q[c80dtu_pkg::REG_E] <= regs_q[c80dtu_pkg::REG_L];
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Instruction fields, first address and the first LHLD byte.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_item.command;
			dst_q  <= cmd_item.dst_reg;
			src_q  <= cmd_item.src_reg;
			pair_q <= cmd_item.pair_sel;
			lo_q   <= cmd_item.imm_low;
			hi_q   <= cmd_item.imm_high;
			addr_q <= first_addr;
		end
		if (state_q == S_SECOND) begin
			byte1_q <= mem_rdata;
		end
	end

	// Result beat, loaded as the instruction retires.
	always_ff @(posedge clk) begin
		if (fin_fire) begin
			res_item_q.cycles_taken <= cyc;
			res_item_q.pc_value     <= pc_q + {14'd0, c80dtu_pkg::cmd_pc_inc(cmd_q)};
			res_item_q.cycle_total  <= total_q + {27'd0, cyc};
			res_item_q.moved_value  <= moved;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/c80dtu_transfer_checker.sv =====
// Checker for the 8080 data transfer unit: predicts every result and compares it.
`timescale 1ns / 1ps

module c80dtu_transfer_checker #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	input  wire logic                 cmd_stall,
	input  wire c80dtu_pkg::in_item_t cmd_item,
	input  wire logic                 res_valid,
	input  wire logic                 res_stall,
	input  wire c80dtu_pkg::out_item_t res_item,
	output int                        fail_count,
	output int                        outstanding
);
	import c80dtu_pkg::*;

	// Architectural state as the block should hold it.
	logic [7:0]  regs [0:7];
	logic [15:0] sp_word = '0;
	logic [15:0] pc_word = '0;
	logic [31:0] cycle_sum = '0;
	logic [7:0]  mem_image [0:65535];

	// Results predicted for accepted beats, oldest first.
	out_item_t expected_results[$];

	initial begin
		fail_count = 0;
		outstanding = 0;
		for (int i = 0; i < 8; i++) begin
			regs[i] = '0;
		end
	end

	// Reduce a 16-bit address to the implemented memory size.
	function automatic int unsigned mem_slot(input logic [15:0] addr);
		return int'(addr) & ((1 << ADDR_BITS) - 1);
	endfunction

	function automatic logic [15:0] pair_word(input logic [1:0] sel);
		logic [15:0] w;
		case (sel)
			PAIR_BC: w = {regs[REG_B], regs[REG_C]};
			PAIR_DE: w = {regs[REG_D], regs[REG_E]};
			PAIR_HL: w = {regs[REG_H], regs[REG_L]};
			default: w = sp_word;
		endcase
		return w;
	endfunction

	// Run one instruction on the state and return the result it should give.
	function automatic out_item_t predict_transfer(input in_item_t it);
		out_item_t  r;
		logic [15:0] imm_addr;
		logic [15:0] imm_next;
		logic [15:0] hl;
		logic [7:0]  moved;
		logic [7:0]  t;
		logic [4:0]  cyc;
		logic [1:0]  pc_step;
		imm_addr = {it.imm_high, it.imm_low};
		imm_next = imm_addr + 16'd1;
		hl = {regs[REG_H], regs[REG_L]};
		moved = '0;
		cyc = CYC_NOP;
		pc_step = 2'd0;
		case (it.command)
			CMD_MOV: begin
				moved = regs[it.src_reg];
				regs[it.dst_reg] = moved;
				cyc = CYC_MOV;
			end
			CMD_LD_HL: begin
				moved = mem_image[mem_slot(hl)];
				regs[it.dst_reg] = moved;
				cyc = CYC_MEM;
			end
			CMD_ST_HL: begin
				moved = regs[it.src_reg];
				mem_image[mem_slot(hl)] = moved;
				cyc = CYC_MEM;
			end
			CMD_MVI: begin
				moved = it.imm_low;
				regs[it.dst_reg] = moved;
				pc_step = 2'd1;
				cyc = CYC_MEM;
			end
			CMD_MVI_M: begin
				moved = it.imm_low;
				mem_image[mem_slot(hl)] = moved;
				pc_step = 2'd1;
				cyc = CYC_IMM;
			end
			CMD_LXI: begin
				case (it.pair_sel)
					PAIR_BC: {regs[REG_B], regs[REG_C]} = imm_addr;
					PAIR_DE: {regs[REG_D], regs[REG_E]} = imm_addr;
					PAIR_HL: {regs[REG_H], regs[REG_L]} = imm_addr;
					default: sp_word = imm_addr;
				endcase
				pc_step = 2'd2;
				cyc = CYC_IMM;
			end
			CMD_LDA: begin
				moved = mem_image[mem_slot(imm_addr)];
				regs[REG_A] = moved;
				pc_step = 2'd2;
				cyc = CYC_DIR;
			end
			CMD_STA: begin
				moved = regs[REG_A];
				mem_image[mem_slot(imm_addr)] = moved;
				pc_step = 2'd2;
				cyc = CYC_DIR;
			end
			CMD_LHLD: begin
				moved = mem_image[mem_slot(imm_addr)];
				regs[REG_L] = moved;
				regs[REG_H] = mem_image[mem_slot(imm_next)];
				pc_step = 2'd2;
				cyc = CYC_WORD;
			end
			CMD_SHLD: begin
				moved = regs[REG_L];
				mem_image[mem_slot(imm_addr)] = moved;
				mem_image[mem_slot(imm_next)] = regs[REG_H];
				pc_step = 2'd2;
				cyc = CYC_WORD;
			end
			CMD_LDAX: begin
				moved = mem_image[mem_slot(pair_word(it.pair_sel))];
				regs[REG_A] = moved;
				cyc = CYC_MEM;
			end
			CMD_STAX: begin
				moved = regs[REG_A];
				mem_image[mem_slot(pair_word(it.pair_sel))] = moved;
				cyc = CYC_MEM;
			end
			CMD_XCHG: begin
				t = regs[REG_H];
				regs[REG_H] = regs[REG_D];
				regs[REG_D] = t;
				t = regs[REG_L];
				regs[REG_L] = regs[REG_E];
				regs[REG_E] = t;
			end
			default: begin
				// Unused codes act as a no-op that still costs cycles.
			end
		endcase
		pc_word = pc_word + 16'(pc_step);
		cycle_sum = cycle_sum + 32'(cyc);
		r.cycles_taken = cyc;
		r.pc_value = pc_word;
		r.cycle_total = cycle_sum;
		r.moved_value = moved;
		return r;
	endfunction

	function automatic void check_field(input string field, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			fail_count++;
		end
	endfunction

	// Watch both channels: predict on each input beat, compare on each result beat.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				regs[i] = '0;
			end
			sp_word = '0;
			pc_word = '0;
			cycle_sum = '0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				expected_results.push_back(predict_transfer(cmd_item));
			end
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with none expected, got %h", $time, res_item);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("cycles_taken", want.cycles_taken, res_item.cycles_taken);
					check_field("pc_value", want.pc_value, res_item.pc_value);
					check_field("cycle_total", want.cycle_total, res_item.cycle_total);
					check_field("moved_value", want.moved_value, res_item.moved_value);
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== tb/sv/tb_cpu8080_data_transfer_unit.sv =====
// Testbench top for the 8080 data transfer unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_cpu8080_data_transfer_unit;
	import c80dtu_pkg::*;

	localparam int RANDOM_ITEMS = 750;
	localparam int WATCHDOG_LIMIT = 2000;

	// Codes the package leaves unnamed.
	localparam logic [3:0] CMD_SPARE_A = 4'd6;
	localparam logic [3:0] CMD_SPARE_B = 4'd14;
	localparam logic [3:0] CMD_SPARE_C = 4'd15;
	localparam logic [2:0] REG_SPARE   = 3'd6;

	typedef enum int {ST_DIRECT, ST_WORD, ST_PAIR, ST_REG_M, ST_IMM_M} store_kind_t;
	typedef enum int {LD_DIRECT, LD_WORD, LD_PAIR, LD_REG_M} load_kind_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	in_item_t  cmd_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	out_item_t res_item;

	int fail_count;
	int outstanding;
	int items_sent = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	logic [9:0] cycle_no = '0;
	logic quiet;

	// Addresses known to hold data, so reads never touch unwritten memory.
	bit written_map [0:65535];
	int unsigned written_q[$];

	always #6 clk = ~clk;

	cpu8080_data_transfer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	c80dtu_transfer_checker transfer_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd_item    (cmd_item),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_item    (res_item),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// One quarter of the time both sides run without idling.
	assign quiet = (cycle_no[9:8] == 2'b11);

	// Result side stalls in bursts, mostly short and now and then long.
	always @(posedge clk) begin
		cycle_no <= cycle_no + 10'd1;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 2) == 0) begin
			res_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
				: $urandom_range(10, 40);
		end else begin
			res_stall <= 1'b0;
			stall_left <= $urandom_range(0, 6);
		end
	end

	// Watchdog on cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic in_item_t instr(input logic [3:0] c, input logic [2:0] d,
			input logic [2:0] s, input logic [1:0] p, input logic [7:0] lo,
			input logic [7:0] hi);
		in_item_t it;
		it.command = c;
		it.dst_reg = d;
		it.src_reg = s;
		it.pair_sel = p;
		it.imm_low = lo;
		it.imm_high = hi;
		return it;
	endfunction

	function automatic bit is_read(input logic [3:0] c);
		return c == CMD_LD_HL || c == CMD_LDA || c == CMD_LHLD || c == CMD_LDAX;
	endfunction

	function automatic void note_write(input logic [15:0] addr);
		if (!written_map[addr]) begin
			written_map[addr] = 1'b1;
			written_q.push_back(addr);
		end
	endfunction

	function automatic logic [15:0] pick_addr();
		case ($urandom_range(0, 11))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hFFFE;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Drive one beat and hold it until accepted, then maybe idle.
	task automatic send(input in_item_t it);
		int gap;
		cmd_item <= it;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) begin
			@(posedge clk);
		end
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Load a pair with an address; the unused fields carry random bits.
	task automatic load_pair(input logic [1:0] p, input logic [15:0] addr);
		send(instr(CMD_LXI, 3'($urandom), 3'($urandom), p, addr[7:0], addr[15:8]));
	endtask

	// Write memory at an address the stimulus knows.
	task automatic seq_store(input store_kind_t kind, input logic [15:0] addr,
			input logic [2:0] r, input logic [1:0] p, input logic [7:0] d);
		logic [15:0] next;
		next = addr + 16'd1;
		case (kind)
			ST_DIRECT: send(instr(CMD_STA, r, 3'($urandom), p, addr[7:0], addr[15:8]));
			ST_WORD: begin
				send(instr(CMD_SHLD, r, 3'($urandom), p, addr[7:0], addr[15:8]));
				note_write(next);
			end
			ST_PAIR: begin
				load_pair(p, addr);
				send(instr(CMD_STAX, r, 3'($urandom), p, d, 8'($urandom)));
			end
			ST_REG_M: begin
				load_pair(PAIR_HL, addr);
				send(instr(CMD_ST_HL, 3'($urandom), r, p, d, 8'($urandom)));
			end
			default: begin
				load_pair(PAIR_HL, addr);
				send(instr(CMD_MVI_M, r, 3'($urandom), p, d, 8'($urandom)));
			end
		endcase
		note_write(addr);
	endtask

	// Read memory; an address not yet written gets a word store first.
	task automatic seq_load(input load_kind_t kind, input logic [15:0] addr,
			input logic [2:0] r, input logic [1:0] p);
		logic [15:0] next;
		next = addr + 16'd1;
		if (!written_map[addr] || (kind == LD_WORD && !written_map[next])) begin
			seq_store(ST_WORD, addr, r, p, 8'($urandom));
		end
		case (kind)
			LD_DIRECT: send(instr(CMD_LDA, r, 3'($urandom), p, addr[7:0], addr[15:8]));
			LD_WORD: send(instr(CMD_LHLD, r, 3'($urandom), p, addr[7:0], addr[15:8]));
			LD_PAIR: begin
				load_pair(p, addr);
				send(instr(CMD_LDAX, r, 3'($urandom), p, 8'($urandom), 8'($urandom)));
			end
			default: begin
				load_pair(PAIR_HL, addr);
				send(instr(CMD_LD_HL, r, 3'($urandom), p, 8'($urandom), 8'($urandom)));
			end
		endcase
	endtask

	// Any command that does not read memory, with random fields.
	task automatic send_noise();
		logic [3:0] c;
		c = 4'($urandom_range(0, 15));
		while (is_read(c)) begin
			c = 4'($urandom_range(0, 15));
		end
		send(instr(c, 3'($urandom), 3'($urandom), 2'($urandom), 8'($urandom),
			8'($urandom)));
	endtask

	initial begin
		logic [15:0] a;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset state, unused codes, register slot six, address extremes.
		send(instr(CMD_XCHG, 3'd7, 3'd7, PAIR_SP, 8'hFF, 8'hFF));
		send(instr(CMD_SPARE_A, 3'd0, 3'd0, PAIR_BC, 8'h00, 8'h00));
		send(instr(CMD_SPARE_B, 3'd7, 3'd7, PAIR_SP, 8'hFF, 8'hFF));
		send(instr(CMD_SPARE_C, 3'd5, 3'd2, PAIR_DE, 8'h5A, 8'hA5));
		send(instr(CMD_MVI, REG_A, 3'd0, PAIR_BC, 8'hFF, 8'h00));
		send(instr(CMD_MVI, REG_SPARE, 3'd7, PAIR_SP, 8'h5A, 8'hFF));
		send(instr(CMD_MOV, REG_B, REG_SPARE, PAIR_BC, 8'h00, 8'h00));
		send(instr(CMD_MOV, REG_SPARE, REG_A, PAIR_HL, 8'h00, 8'h00));
		seq_store(ST_DIRECT, 16'hFFFF, REG_B, PAIR_BC, 8'h00);
		seq_load(LD_DIRECT, 16'hFFFF, REG_C, PAIR_DE);
		seq_store(ST_WORD, 16'hFFFF, REG_A, PAIR_SP, 8'h00);
		seq_load(LD_WORD, 16'hFFFF, REG_E, PAIR_HL);
		seq_store(ST_PAIR, 16'h0000, REG_H, PAIR_SP, 8'h00);
		seq_load(LD_PAIR, 16'h0000, REG_L, PAIR_BC);
		seq_load(LD_PAIR, 16'hFFFF, REG_D, PAIR_DE);
		seq_store(ST_REG_M, 16'h8000, REG_SPARE, PAIR_BC, 8'h00);
		seq_store(ST_IMM_M, 16'h7FFF, REG_A, PAIR_DE, 8'h00);
		seq_load(LD_REG_M, 16'h8000, REG_SPARE, PAIR_HL);
		seq_load(LD_PAIR, 16'h7FFF, REG_A, PAIR_HL);
		seq_load(LD_PAIR, 16'h8000, REG_A, PAIR_SP);
		send(instr(CMD_XCHG, 3'd0, 3'd0, PAIR_BC, 8'h00, 8'h00));

		// Random: mostly stores and loads at tracked addresses, some loose commands.
		while (items_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2: send_noise();
				3, 4, 5: seq_store(store_kind_t'($urandom_range(0, 4)), pick_addr(),
					3'($urandom), 2'($urandom), 8'($urandom));
				default: begin
					a = 16'(written_q[$urandom_range(0, written_q.size() - 1)]);
					seq_load(load_kind_t'($urandom_range(0, 3)), a, 3'($urandom),
						2'($urandom));
				end
			endcase
		end
		cmd_valid <= 1'b0;

		// Drain the results still owed, then allow a few more cycles.
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/c80dtu_pkg.sv
hw/rtl/c80dtu_ram.sv
hw/rtl/cpu8080_data_transfer_unit.sv
tb/sv/c80dtu_transfer_checker.sv
tb/sv/tb_cpu8080_data_transfer_unit.sv
